### rtl/field25519_square_carry_assert.svh
// Assertion macros shared by the field squaring pipeline.
`ifndef FIELD25519_SQUARE_CARRY_ASSERT_SVH
`define FIELD25519_SQUARE_CARRY_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define F25SQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define F25SQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/f25sq_pkg.sv
// Shared types, constants and index helpers for the field squaring pipeline.
package f25sq_pkg;

	localparam int NLIMBS = 10;
	localparam int NPAIRS = NLIMBS * (NLIMBS + 1) / 2;
	localparam int LIMB_W = 28;
	localparam int PROD_W = 2 * LIMB_W;
	localparam int ACC_W = 64;
	localparam int CARRY_W = ACC_W - 25;
	localparam logic [ACC_W-1:0] FOLD_FACTOR = 64'h13;
	localparam logic [ACC_W-1:0] MASK26 = 64'h3ffffff;
	localparam logic [ACC_W-1:0] MASK25 = 64'h1ffffff;

	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [ACC_W-1:0] acc_t;
	typedef logic [CARRY_W-1:0] carry_t;

	// Pipeline advance control shared by all stages.
	typedef struct packed {
		logic adv;
	} pipe_ctl_t;

	// Flat index of the unordered limb pair (i, j) with i <= j.
	function automatic int pair_idx(input int i, input int j);
		return i * (2 * NLIMBS - 1 - i) / 2 + j;
	endfunction

	// Column weight of a pair: symmetric doubling, odd-odd doubling, wrap fold.
	function automatic int pair_weight(input int i, input int j);
		int w;
		w = (i == j) ? 1 : 2;
		if ((i % 2 == 1) && (j % 2 == 1))
			w = w * 2;
		if (i + j >= NLIMBS)
			w = w * 19;
		return w;
	endfunction

endpackage

### rtl/field25519_square_carry.sv
// Top level of the pipelined GF(2^255-19) squaring with carry.
//
// Input channel: in_valid / in_stall with ten limb ports in_limb0..in_limb9;
// a transaction is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with ten limb ports out_limb0..9.
// Pipeline: six register stages (products, weighting, column sums and three
// carry stages); out_valid rises when an accepted transaction reaches the
// last stage register, and the result stays there until it is taken.
// Throughput: one squaring per clock while the pipe is not held; each stage holds one transaction.
// All stages advance together; when out_valid is high and out_stall is
// high, the whole pipe holds and in_stall is raised in the same cycle, so
// nothing is dropped or repeated and the waiting result stays unchanged.
// Reset (arst_n low) clears all valid bits; the pipe comes up empty.
// Inputs beyond the loose limb bounds give the column sums modulo 2^64.
module field25519_square_carry import f25sq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [27:0] in_limb0,
	input  logic [26:0] in_limb1,
	input  logic [27:0] in_limb2,
	input  logic [26:0] in_limb3,
	input  logic [27:0] in_limb4,
	input  logic [26:0] in_limb5,
	input  logic [27:0] in_limb6,
	input  logic [26:0] in_limb7,
	input  logic [27:0] in_limb8,
	input  logic [26:0] in_limb9,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [25:0] out_limb0,
	output logic [24:0] out_limb1,
	output logic [26:0] out_limb2,
	output logic [24:0] out_limb3,
	output logic [25:0] out_limb4,
	output logic [24:0] out_limb5,
	output logic [25:0] out_limb6,
	output logic [24:0] out_limb7,
	output logic [25:0] out_limb8,
	output logic [24:0] out_limb9
);

`include "field25519_square_carry_assert.svh"

	pipe_ctl_t ctl;
	limb_t     limbs [NLIMBS];
	logic      valid_s2, valid_s3;
	acc_t      terms_s2 [NPAIRS];
	acc_t      col_s3 [NLIMBS];

	// Hold every stage while a finished result waits
	assign ctl.adv  = !(out_valid && out_stall);
	assign in_stall = !ctl.adv;

	assign limbs[0] = in_limb0;
	assign limbs[1] = LIMB_W'(in_limb1);
	assign limbs[2] = in_limb2;
	assign limbs[3] = LIMB_W'(in_limb3);
	assign limbs[4] = in_limb4;
	assign limbs[5] = LIMB_W'(in_limb5);
	assign limbs[6] = in_limb6;
	assign limbs[7] = LIMB_W'(in_limb7);
	assign limbs[8] = in_limb8;
	assign limbs[9] = LIMB_W'(in_limb9);

	f25sq_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.valid_in (in_valid),
		.limbs    (limbs),
		.valid_s2 (valid_s2),
		.terms_s2 (terms_s2)
	);

	f25sq_col u_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.valid_in (valid_s2),
		.terms    (terms_s2),
		.valid_s3 (valid_s3),
		.col_s3   (col_s3)
	);

	f25sq_carry u_carry (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.valid_in (valid_s3),
		.col      (col_s3),
		.valid_s6 (out_valid),
		.r0_s6    (out_limb0),
		.r1_s6    (out_limb1),
		.r2_s6    (out_limb2),
		.r3_s6    (out_limb3),
		.r4_s6    (out_limb4),
		.r5_s6    (out_limb5),
		.r6_s6    (out_limb6),
		.r7_s6    (out_limb7),
		.r8_s6    (out_limb8),
		.r9_s6    (out_limb9)
	);

	// An accepted transaction reaches the output once it has advanced unstalled through every stage
	`F25SQ_ASSERT(a_latency, (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid, "accepted transaction did not reach the output")
	// Advancing with no input through every stage leaves the output empty
	`F25SQ_ASSERT(a_no_phantom, (!in_valid && !in_stall) ##1 (!in_valid && !in_stall) ##1 (!in_valid && !in_stall) ##1 (!in_valid && !in_stall) ##1 (!in_valid && !in_stall) ##1 (!in_valid && !in_stall) |=> !out_valid, "result appeared without an input transaction")
	// Reset leaves no result pending
	`F25SQ_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "output valid during reset")

endmodule

### rtl/f25sq_mul.sv
// Limb pair products (stage 1) and their column weighting (stage 2).
module f25sq_mul import f25sq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  logic      valid_in,
	input  limb_t     limbs [NLIMBS],
	output logic      valid_s2,
	output acc_t      terms_s2 [NPAIRS]
);

	logic  valid_s1;
	prod_t prod_s1 [NPAIRS];

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	// Form one product per unordered pair, then scale it by its constant weight
	for (genvar gi = 0; gi < NLIMBS; gi++) begin : g_row
		for (genvar gj = gi; gj < NLIMBS; gj++) begin : g_col
			localparam int P = pair_idx(gi, gj);
			localparam logic [ACC_W-1:0] W = ACC_W'(pair_weight(gi, gj));
			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					prod_s1[P]  <= PROD_W'(limbs[gi]) * PROD_W'(limbs[gj]);
					terms_s2[P] <= ACC_W'(prod_s1[P]) * W;
				end
			end
		end
	end

endmodule

### rtl/f25sq_col.sv
// Column sums of the weighted pair terms, modulo 2^64 (stage 3).
module f25sq_col import f25sq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  logic      valid_in,
	input  acc_t      terms [NPAIRS],
	output logic      valid_s3,
	output acc_t      col_s3 [NLIMBS]
);

	acc_t col_d [NLIMBS];

	// Gather the pairs that land in each column
	always_comb begin
		for (int k = 0; k < NLIMBS; k++) begin
			col_d[k] = '0;
			for (int i = 0; i < NLIMBS; i++) begin
				for (int j = i; j < NLIMBS; j++) begin
					if ((i + j) % NLIMBS == k)
						col_d[k] = col_d[k] + terms[pair_idx(i, j)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (ctl.adv)
			valid_s3 <= valid_in;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv)
			col_s3 <= col_d;
	end

endmodule

### rtl/f25sq_carry.sv
// Carry chain over the columns and the fold of the top carry (stages 4 to 6).
module f25sq_carry import f25sq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pipe_ctl_t   ctl,
	input  logic        valid_in,
	input  acc_t        col [NLIMBS],
	output logic        valid_s6,
	output logic [25:0] r0_s6,
	output logic [24:0] r1_s6,
	output logic [26:0] r2_s6,
	output logic [24:0] r3_s6,
	output logic [25:0] r4_s6,
	output logic [24:0] r5_s6,
	output logic [25:0] r6_s6,
	output logic [24:0] r7_s6,
	output logic [25:0] r8_s6,
	output logic [24:0] r9_s6
);

	logic        valid_s4, valid_s5;
	logic [25:0] r0_s4, r0_s5, r2_s4, r2_s5;
	logic [24:0] r1_s4, r1_s5, r3_s4, r3_s5;
	logic [25:0] r4_s5, r6_s5;
	logic [24:0] r5_s5, r7_s5;
	carry_t      c_s4, c_s5;
	acc_t        hi_s4 [6];
	acc_t        hi_s5 [2];

	acc_t   a0, a1, a2, a3, a4, a5, a6, a7, a8, a9;
	acc_t   f0, f1;
	logic [26:0] f2;

	// Carry through limbs 0 to 3
	always_comb begin
		a0 = col[0];
		a1 = col[1] + (a0 >> 26);
		a2 = col[2] + (a1 >> 25);
		a3 = col[3] + (a2 >> 26);
	end

	// Carry through limbs 4 to 7
	always_comb begin
		a4 = hi_s4[0] + ACC_W'(c_s4);
		a5 = hi_s4[1] + (a4 >> 26);
		a6 = hi_s4[2] + (a5 >> 25);
		a7 = hi_s4[3] + (a6 >> 26);
	end

	// Carry through limbs 8 and 9, fold the top carry times 19, settle limbs 0 to 2
	always_comb begin
		a8 = hi_s5[0] + ACC_W'(c_s5);
		a9 = hi_s5[1] + (a8 >> 26);
		f0 = ACC_W'(r0_s5) + (a9 >> 25) * FOLD_FACTOR;
		f1 = ACC_W'(r1_s5) + (f0 >> 26);
		f2 = 27'(ACC_W'(r2_s5) + (f1 >> 25));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (ctl.adv) begin
			valid_s4 <= valid_in;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			// stage 4
			r0_s4 <= 26'(a0 & MASK26);
			r1_s4 <= 25'(a1 & MASK25);
			r2_s4 <= 26'(a2 & MASK26);
			r3_s4 <= 25'(a3 & MASK25);
			c_s4  <= CARRY_W'(a3 >> 25);
			for (int k = 0; k < 6; k++)
				hi_s4[k] <= col[k + 4];
			// stage 5
			r0_s5 <= r0_s4;
			r1_s5 <= r1_s4;
			r2_s5 <= r2_s4;
			r3_s5 <= r3_s4;
			r4_s5 <= 26'(a4 & MASK26);
			r5_s5 <= 25'(a5 & MASK25);
			r6_s5 <= 26'(a6 & MASK26);
			r7_s5 <= 25'(a7 & MASK25);
			c_s5  <= CARRY_W'(a7 >> 25);
			hi_s5[0] <= hi_s4[4];
			hi_s5[1] <= hi_s4[5];
			// stage 6
			r0_s6 <= 26'(f0 & MASK26);
			r1_s6 <= 25'(f1 & MASK25);
			r2_s6 <= f2;
			r3_s6 <= r3_s5;
			r4_s6 <= r4_s5;
			r5_s6 <= r5_s5;
			r6_s6 <= r6_s5;
			r7_s6 <= r7_s5;
			r8_s6 <= 26'(a8 & MASK26);
			r9_s6 <= 25'(a9 & MASK25);
		end
	end

endmodule

### verif/tb_field25519_square_carry.sv
// Testbench for the pipelined GF(2^255-19) squaring with carry.
`timescale 1ns / 100ps

module tb_field25519_square_carry;
	import f25sq_pkg::*;

	localparam int EVEN_MAX = 201326592;
	localparam int ODD_MAX = 100663296;
	localparam int RAND_ITEMS = 1530;
	localparam int N_DIRECTED = 8;

	typedef logic [27:0] limbs_in_t [NLIMBS];
	typedef logic [26:0] limbs_out_t [NLIMBS];

	// One square: the ten output limbs.
	typedef struct {
		logic [26:0] l [NLIMBS];
	} square_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [27:0] in_limb0 = '0, in_limb2 = '0, in_limb4 = '0, in_limb6 = '0, in_limb8 = '0;
	logic [26:0] in_limb1 = '0, in_limb3 = '0, in_limb5 = '0, in_limb7 = '0, in_limb9 = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [25:0] out_limb0, out_limb4, out_limb6, out_limb8;
	logic [24:0] out_limb1, out_limb3, out_limb5, out_limb7, out_limb9;
	logic [26:0] out_limb2;

	square_t squares_due[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	bit hold_off = 1'b0;
	bit quiet = 1'b0;

	field25519_square_carry dut (.*);

	always #1 clk = ~clk;

	// Square a field element into ten carried limbs.
	function automatic square_t square_limbs(input limbs_in_t a);
		logic [63:0] col [NLIMBS];
		logic [63:0] x [NLIMBS];
		logic [63:0] term, acc, carry;
		square_t s;
		int k;
		for (int i = 0; i < NLIMBS; i++) begin
			x[i] = (i % 2) ? {37'd0, a[i][26:0]} : {36'd0, a[i]};
			col[i] = '0;
		end
		for (int i = 0; i < NLIMBS; i++) begin
			for (int j = 0; j < NLIMBS; j++) begin
				term = x[i] * x[j];
				k = i + j;
				if ((i % 2) && (j % 2))
					term = term * 2;
				if (k >= NLIMBS) begin
					term = term * 19;
					k = k - NLIMBS;
				end
				col[k] = col[k] + term;
			end
		end
		carry = '0;
		for (int i = 0; i < NLIMBS; i++) begin
			acc = col[i] + carry;
			if (i % 2) begin
				col[i] = acc & MASK25;
				carry = acc >> 25;
			end else begin
				col[i] = acc & MASK26;
				carry = acc >> 26;
			end
		end
		acc = col[0] + carry * 19;
		col[0] = acc & MASK26;
		acc = col[1] + (acc >> 26);
		col[1] = acc & MASK25;
		col[2] = col[2] + (acc >> 25);
		for (int i = 0; i < NLIMBS; i++)
			s.l[i] = col[i][26:0];
		return s;
	endfunction

	// Offer one transaction and wait until it is taken.
	task automatic send_square(input limbs_in_t a);
		while (!quiet && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{in_limb0, in_limb2, in_limb4, in_limb6, in_limb8} <= {a[0], a[2], a[4], a[6], a[8]};
		in_limb1 <= a[1][26:0];
		in_limb3 <= a[3][26:0];
		in_limb5 <= a[5][26:0];
		in_limb7 <= a[7][26:0];
		in_limb9 <= a[9][26:0];
		squares_due.push_back(square_limbs(a));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stimulus: directed table, then random elements.
	initial begin
		limbs_in_t directed [N_DIRECTED];
		limbs_in_t a;
		int kind;
		for (int r = 0; r < N_DIRECTED; r++)
			for (int i = 0; i < NLIMBS; i++)
				case (r)
					0: directed[r][i] = '0;
					1: directed[r][i] = (i == 0) ? 28'd1 : '0;
					2: directed[r][i] = 28'((i % 2) ? ODD_MAX : EVEN_MAX);
					3: directed[r][i] = (i % 2) ? 28'h1ffffff : 28'h3ffffff;
					4: directed[r][i] = (i == 9) ? 28'(ODD_MAX) : '0;
					5: directed[r][i] = (i % 2) ? 28'h7ffffff : 28'hfffffff;
					6: directed[r][i] = (i % 2) ? 28'h5555555 : 28'haaaaaaa;
					default: directed[r][i] = (i % 2) ? 28'h2aaaaaa : 28'h5555555;
				endcase
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[r])
			send_square(directed[r]);
		for (int n = 0; n < RAND_ITEMS; n++) begin
			quiet = (n >= 600 && n < 800);
			if (n == 300)
				hold_off = 1'b1;
			kind = $urandom_range(9);
			for (int i = 0; i < NLIMBS; i++)
				if (kind == 0)
					a[i] = 28'($urandom()) & ((i % 2) ? 28'h7ffffff : 28'hfffffff);
				else if (kind == 1)
					a[i] = $urandom_range(1) ? 28'((i % 2) ? ODD_MAX : EVEN_MAX) : '0;
				else
					a[i] = 28'($urandom_range((i % 2) ? ODD_MAX : EVEN_MAX));
			send_square(a);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stalls, one long hold-off to fill the pipe.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (40) @(posedge clk);
				hold_off = 1'b0;
			end
			out_stall <= (!quiet && $urandom_range(99) < 10);
		end
	end

	// Check each accepted result against the oldest expected square.
	always @(posedge clk) begin
		square_t want;
		limbs_out_t got;
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_limb0, out_limb1, out_limb2, out_limb3, out_limb4,
				out_limb5, out_limb6, out_limb7, out_limb8, out_limb9};
			if (squares_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction");
			end else begin
				want = squares_due.pop_front();
				bad = 1'b0;
				for (int i = 0; i < NLIMBS; i++)
					if (got[i] !== want.l[i]) begin
						bad = 1'b1;
						if (mismatches < 10)
							$display("limb %0d: expected %h, got %h", i, want.l[i], got[i]);
					end
				if (bad)
					mismatches++;
			end
		end
	end

	// Drain and report.
	initial begin
		wait (stim_done);
		wait (squares_due.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_field25519_square_carry: done, clean");
		else
			$display("tb_field25519_square_carry: done, errors");
		$finish;
	end

	// Timeout.
	initial begin
		#200000;
		$display("tb_field25519_square_carry: done, errors");
		$finish;
	end

endmodule

### field25519_square_carry.f
+incdir+rtl
rtl/f25sq_pkg.sv
rtl/f25sq_mul.sv
rtl/f25sq_col.sv
rtl/f25sq_carry.sv
rtl/field25519_square_carry.sv
verif/tb_field25519_square_carry.sv
